FILE: rtl/adcss_pkg.sv
package adcss_pkg;

  // sizing
  localparam int NUM_SLOTS   = 3;
  localparam int SAMPLE_BITS = 12;
  localparam int CH_W        = 8;
  localparam int CNT_W       = 8;
  localparam int OUT_CH_W    = 5;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // register map
  localparam int NUM_REGS    = 2 * NUM_SLOTS + 2;
  localparam int REG_CHAN0   = 0;
  localparam int REG_AVG0    = NUM_SLOTS;
  localparam int REG_IREF    = 2 * NUM_SLOTS;
  localparam int REG_ASYNC   = 2 * NUM_SLOTS + 1;
  localparam int IDX_W       = $clog2(NUM_REGS);
  localparam int ADDR_W      = IDX_W + 2;
  localparam int DATA_W      = 32;

  // channel codes
  localparam logic [CH_W-1:0] CH_NONE       = 8'hFF;
  localparam logic [CH_W-1:0] CH_LAST_VALID = 8'd22;
  localparam logic [CH_W-1:0] CH_BANDGAP    = 8'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic                   conv_start;
    logic [OUT_CH_W-1:0]    conv_channel;
    logic                   ref_internal;
    logic                   result_valid;
    logic [OUT_CH_W-1:0]    result_channel;
    logic [SAMPLE_BITS-1:0] result_value;
    logic                   round_done;
  } out_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][CH_W-1:0]  chan;
    logic [NUM_SLOTS-1:0][CNT_W-1:0] avg;
    logic [CH_W-1:0]                 iref;
    logic                            async_mode;
  } cfg_t;

  // reset channel of a slot
  function automatic logic [CH_W-1:0] chan_reset(input int idx);
    logic [CH_W-1:0] v;
    v = (idx == 0) ? CH_BANDGAP : '0;
    return v;
  endfunction

  // reset average count of a slot
  function automatic logic [CNT_W-1:0] avg_reset(input int idx);
    logic [CNT_W-1:0] v;
    unique case (idx)
      0:       v = 8'd8;
      1:       v = 8'd6;
      2:       v = 8'd10;
      default: v = 8'd1;
    endcase
    return v;
  endfunction

  // channel numbers that mark a slot unused
  function automatic logic chan_invalid(input logic [CH_W-1:0] ch);
    return (ch == CH_NONE) || ((ch > CH_LAST_VALID) && (ch < CH_BANDGAP));
  endfunction

endpackage

FILE: rtl/adcss_cfg.sv
module adcss_cfg
  import adcss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [NUM_SLOTS-1:0][CH_W-1:0]  chan_q;
  logic [NUM_SLOTS-1:0][CNT_W-1:0] avg_q;
  logic [CH_W-1:0]                 iref_q;
  logic                            async_q;
  logic [IDX_W-1:0]                idx;
  logic                            wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        chan_q[i] <= chan_reset(i);
        avg_q[i]  <= avg_reset(i);
      end
      iref_q  <= '0;
      async_q <= 1'b0;
    end else if (wr) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (idx == IDX_W'(REG_CHAN0 + i)) chan_q[i] <= pwdata[CH_W-1:0];
        if (idx == IDX_W'(REG_AVG0 + i))  avg_q[i]  <= pwdata[CNT_W-1:0];
      end
      if (idx == IDX_W'(REG_IREF))  iref_q  <= pwdata[CH_W-1:0];
      if (idx == IDX_W'(REG_ASYNC)) async_q <= pwdata[0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (idx == IDX_W'(REG_CHAN0 + i)) prdata = DATA_W'(chan_q[i]);
      if (idx == IDX_W'(REG_AVG0 + i))  prdata = DATA_W'(avg_q[i]);
    end
    if (idx == IDX_W'(REG_IREF))  prdata = DATA_W'(iref_q);
    if (idx == IDX_W'(REG_ASYNC)) prdata = DATA_W'(async_q);
  end

  assign cfg_o.chan       = chan_q;
  assign cfg_o.avg        = avg_q;
  assign cfg_o.iref       = iref_q;
  assign cfg_o.async_mode = async_q;

endmodule

FILE: rtl/adcss_div.sv
module adcss_div
  import adcss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic [ITER_W-1:0] iter_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // one restoring step per cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      iter_q <= ITER_W'(SUM_W);
    end else if (busy_q) begin
      iter_q <= iter_q - 1'b1;
      if (iter_q == ITER_W'(1)) busy_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (iter_q == ITER_W'(1));
  assign quotient_o = quo_q;

endmodule

FILE: rtl/adc_scan_sequencer_averaging_core.sv
// ADC scan sequencer with oversampling average. Each input word is a poll
// (req_type 0) or a conversion sample (req_type 1), and each one yields
// exactly one output word carrying the conversion request, the reference
// select and, when a slot finishes, its truncated average. Polls, ignored
// words and samples that do not complete an average load their output word
// when taken. A sample that completes an average instead starts the
// bit-serial restoring divider, which forms sum / count one quotient bit per
// cycle; in_stall_o is high meanwhile. Output words sit in a register,
// and a new input word is taken only when that register is empty or hands its
// word on in the same cycle, so a stalled output word holds off the input.
// Slot channels, average counts, the internal-reference channel and async
// mode are set over the APB port at byte addresses 4*i.
module adc_scan_sequencer_averaging_core
  import adcss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  state_e state_q, state_d;

  logic [NUM_SLOTS-1:0] marks_q, marks_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic                 conv_q, conv_d;
  logic                 ref_q, ref_d;
  logic [OUT_CH_W-1:0]  res_ch_q, res_ch_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  logic                 out_free;
  logic                 accept;
  logic                 out_load;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [SUM_W-1:0]     quotient;

  logic [NUM_SLOTS-1:0] inv_vec;
  logic [NUM_SLOTS-1:0] same_vec;
  logic [NUM_SLOTS-1:0] pend;
  logic                 found;
  logic [SLOT_W-1:0]    found_idx;
  logic [CH_W-1:0]      found_ch;
  logic [CH_W-1:0]      cur_ch;
  logic [CNT_W-1:0]     target;
  logic [CNT_W-1:0]     cnt_n;
  logic [SUM_W-1:0]     sum_n;

  adcss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  adcss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_n),
    .divisor_i  (cnt_n),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // per-slot channel checks
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      inv_vec[i]  = chan_invalid(cfg.chan[i]);
      same_vec[i] = (cfg.chan[i] == cur_ch) || (cur_q == SLOT_W'(i));
    end
  end

  // first pending slot
  assign pend = (state_q == ST_IDLE && !in_data_i.req_type) ? ~inv_vec : ~marks_q;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && pend[i]) begin
        found     = 1'b1;
        found_idx = SLOT_W'(i);
      end
    end
  end

  assign found_ch = cfg.chan[found_idx];
  assign cur_ch   = cfg.chan[cur_q];
  assign target   = (cfg.avg[cur_q] == '0) ? CNT_W'(1) : cfg.avg[cur_q];
  assign cnt_n    = cnt_q + 1'b1;
  assign sum_n    = sum_q + SUM_W'(in_data_i.sample);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (div_start) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    marks_d   = marks_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    conv_d    = conv_q;
    ref_d     = ref_q;
    res_ch_d  = res_ch_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    out_d     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          if (!in_data_i.req_type) begin
            if (!conv_q) begin
              marks_d = inv_vec;
              ref_d   = 1'b0;
              if (found) begin
                cur_d              = found_idx;
                cnt_d              = '0;
                sum_d              = '0;
                conv_d             = 1'b1;
                ref_d              = (found_ch == cfg.iref);
                out_d.conv_start   = 1'b1;
                out_d.conv_channel = found_ch[OUT_CH_W-1:0];
              end else begin
                out_d.round_done = cfg.async_mode;
              end
            end
          end else if (conv_q) begin
            cnt_d = cnt_n;
            sum_d = sum_n;
            if (cnt_n < target) begin
              out_d.conv_start   = 1'b1;
              out_d.conv_channel = cur_ch[OUT_CH_W-1:0];
            end else begin
              out_load  = 1'b0;
              conv_d    = 1'b0;
              marks_d   = marks_q | same_vec;
              res_ch_d  = cur_ch[OUT_CH_W-1:0];
              div_start = 1'b1;
            end
          end
          out_d.ref_internal = ref_d;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_d.result_valid   = 1'b1;
          out_d.result_channel = res_ch_q;
          out_d.result_value   = quotient[SAMPLE_BITS-1:0];
          if (found) begin
            cur_d              = found_idx;
            cnt_d              = '0;
            sum_d              = '0;
            conv_d             = 1'b1;
            ref_d              = ref_q | (found_ch == cfg.iref);
            out_d.conv_start   = 1'b1;
            out_d.conv_channel = found_ch[OUT_CH_W-1:0];
          end else begin
            out_d.round_done = cfg.async_mode;
          end
          out_d.ref_internal = ref_d;
        end
      end
      default: ;
    endcase
  end

  // output register
  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      marks_q     <= '1;
      cur_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      conv_q      <= 1'b0;
      ref_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      marks_q     <= marks_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      conv_q      <= conv_d;
      ref_q       <= ref_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ch_q <= res_ch_d;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide state");

  a_cur_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_q |-> !marks_q[cur_q])
    else $error("converting slot already marked done");

  a_fin_idle_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !conv_q)
    else $error("conversion still open while finishing a result");

  a_start_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.conv_start && out_data_o.round_done))
    else $error("conversion request and round end in one word");

endmodule
